>>> rtl/core/gn3d_pkg.sv
// shared constants and permutation rom for the 3d gradient noise pipeline
package gn3d_pkg;

  localparam int OUT_FRAC   = 16;
  localparam int OUT_W      = 18;
  localparam int COORD_BITS = 32;

  // standard permutation table
  localparam logic [7:0] PERM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  // gradient selection codes (low four hash bits)
  localparam logic [3:0] H_U_IS_Y = 4'd8;
  localparam logic [3:0] H_V_IS_Y = 4'd4;
  localparam logic [3:0] H_V_X_A  = 4'd12;
  localparam logic [3:0] H_V_X_B  = 4'd14;

endpackage

>>> rtl/core/gradient_noise_3d.sv
// 3d improved gradient noise, fully pipelined, one point per cycle unless stalled
// order: coordinate split, hash and fade chains, corner gradients, lerp levels, output register
// throughput: one item per cycle; stall halts all stages together (global enable)
// the output register stays visible while stalled; nothing is dropped or repeated
// rst_ni asynchronously clears all valid bits; the permutation table is constant
module gradient_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [gn3d_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [gn3d_pkg::COORD_BITS-1:0] coord_y_i,
  input  logic signed [gn3d_pkg::COORD_BITS-1:0] coord_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [17:0]                    noise_value_o
);

  localparam int NS = 15;              // pipeline stages
  localparam int F  = FRAC_BITS;
  localparam int VW = F + 2;           // fraction or fraction - one, signed
  localparam int GW = F + 3;           // gradient dot, signed
  localparam int DW = F + 5;           // interpolated values, signed with headroom
  localparam int PW = 2 * DW + 2;      // product width
  localparam logic signed [DW-1:0] ONE_D = DW'(1) <<< F;

  typedef logic [7:0] h8_t;

  logic adv;
  logic [NS-1:0] vld_q;

  // whole pipeline advances unless a valid result is held at the output
  assign adv         = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[NS-1];

  // signed truncating product, floor toward minus infinity
  function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [PW-1:0] p;
    p = PW'(a) * PW'(b);
    return DW'(p >>> F);
  endfunction

  function automatic logic signed [GW-1:0] grad(input h8_t hs,
      input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
      input logic signed [VW-1:0] z);
    logic [3:0] h;
    logic signed [GW-1:0] u;
    logic signed [GW-1:0] v;
    h = hs[3:0];
    u = (h < gn3d_pkg::H_U_IS_Y) ? GW'(x) : GW'(y);
    if (h < gn3d_pkg::H_V_IS_Y) v = GW'(y);
    else if (h == gn3d_pkg::H_V_X_A || h == gn3d_pkg::H_V_X_B) v = GW'(x);
    else v = GW'(z);
    return (h[0] ? -u : u) + (h[1] ? -v : v);
  endfunction

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  // stage 1: split coordinates into cell index and fraction
  logic [7:0] cx_q, cy_q, cz_q;
  logic signed [DW-1:0] fx_q, fy_q, fz_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q <= coord_x_i[F +: 8];
      cy_q <= coord_y_i[F +: 8];
      cz_q <= coord_z_i[F +: 8];
      fx_q <= DW'({1'b0, coord_x_i[F-1:0]});
      fy_q <= DW'({1'b0, coord_y_i[F-1:0]});
      fz_q <= DW'({1'b0, coord_z_i[F-1:0]});
    end
  end

  // fractions and cell data travel down the pipe as arrays per axis
  logic signed [DW-1:0] fr_q [3][2:5];
  logic [7:0]           hz_q [2:3];

  // fade pipeline per axis: s2 t*t and 6t-15, s3 t^2*t and t*(6t-15)+10,
  // s4 final product
  logic signed [DW-1:0] t2_q [3], a_q [3], t3_q [3], in_q [3], fd_q [3];
  logic signed [DW-1:0] fdp_q [3][6:NS-1];
  logic signed [DW-1:0] fin [3];
  assign fin[0] = fx_q;
  assign fin[1] = fy_q;
  assign fin[2] = fz_q;

  // hash chain: s2 A,B from X; s3 perm(A),perm(A+1),perm(B),perm(B+1)
  // s4 AA..BB (+Z); s5 eight corner hashes
  logic [7:0] a_h_q, b_h_q;
  logic [7:0] p4_q [4];
  logic [7:0] m4_q [4];
  h8_t        cor_q [8];
  logic signed [GW-1:0] g_q [8];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        fr_q[k][2] <= fin[k];
        for (int s = 3; s < 6; s++) fr_q[k][s] <= fr_q[k][s-1];
        t2_q[k] <= mulq(fin[k], fin[k]);
        a_q[k]  <= DW'(6 * fin[k] - 15 * ONE_D);
        t3_q[k] <= mulq(t2_q[k], fr_q[k][2]);
        in_q[k] <= DW'(mulq(fr_q[k][2], a_q[k]) + 10 * ONE_D);
        fd_q[k] <= mulq(t3_q[k], in_q[k]);
        fdp_q[k][6] <= fd_q[k];
        for (int s = 7; s < NS; s++) fdp_q[k][s] <= fdp_q[k][s-1];
      end
      hz_q[2] <= cz_q;
      hz_q[3] <= hz_q[2];
      a_h_q <= gn3d_pkg::PERM[cx_q] + cy_q;
      b_h_q <= gn3d_pkg::PERM[8'(cx_q + 8'd1)] + cy_q;
      p4_q[0] <= gn3d_pkg::PERM[a_h_q];
      p4_q[1] <= gn3d_pkg::PERM[8'(a_h_q + 8'd1)];
      p4_q[2] <= gn3d_pkg::PERM[b_h_q];
      p4_q[3] <= gn3d_pkg::PERM[8'(b_h_q + 8'd1)];
      for (int k = 0; k < 4; k++) m4_q[k] <= p4_q[k] + hz_q[3];
      // order: AA, BA, AB, BB, then +1 variants
      cor_q[0] <= gn3d_pkg::PERM[m4_q[0]];
      cor_q[1] <= gn3d_pkg::PERM[m4_q[2]];
      cor_q[2] <= gn3d_pkg::PERM[m4_q[1]];
      cor_q[3] <= gn3d_pkg::PERM[m4_q[3]];
      cor_q[4] <= gn3d_pkg::PERM[8'(m4_q[0] + 8'd1)];
      cor_q[5] <= gn3d_pkg::PERM[8'(m4_q[2] + 8'd1)];
      cor_q[6] <= gn3d_pkg::PERM[8'(m4_q[1] + 8'd1)];
      cor_q[7] <= gn3d_pkg::PERM[8'(m4_q[3] + 8'd1)];
    end
  end

  // stage 6: gradient dots at the eight corners (fractions at stage 5)
  logic signed [VW-1:0] px [2], py [2], pz [2];
  assign px[0] = VW'(fr_q[0][5]);
  assign px[1] = VW'(fr_q[0][5] - ONE_D);
  assign py[0] = VW'(fr_q[1][5]);
  assign py[1] = VW'(fr_q[1][5] - ONE_D);
  assign pz[0] = VW'(fr_q[2][5]);
  assign pz[1] = VW'(fr_q[2][5] - ONE_D);

  // lerp pipeline: each level is a subtract stage, a multiply stage, then an add stage
  logic signed [DW-1:0] d1_q [4], l1_q [4];
  logic signed [DW-1:0] b1_q [4], b1d_q [4];
  logic signed [DW-1:0] d2_q [2], l2_q [2], b2_q [2], b2d_q [2];
  logic signed [DW-1:0] d3_q, b3_q, b3d_q;
  logic signed [DW-1:0] p1_q [4], p2_q [2], p3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        g_q[c] <= grad(cor_q[c], px[c[0]], py[c[1]], pz[c[2]]);
      end
      // level 1 along x (u = fade x)
      for (int k = 0; k < 4; k++) begin
        d1_q[k]  <= DW'(g_q[2*k+1]) - DW'(g_q[2*k]);
        b1_q[k]  <= DW'(g_q[2*k]);
        p1_q[k]  <= mulq(fdp_q[0][8], d1_q[k]);
        b1d_q[k] <= b1_q[k];
        l1_q[k]  <= b1d_q[k] + p1_q[k];
      end
      // level 2 along y
      for (int k = 0; k < 2; k++) begin
        d2_q[k]  <= l1_q[2*k+1] - l1_q[2*k];
        b2_q[k]  <= l1_q[2*k];
        p2_q[k]  <= mulq(fdp_q[1][11], d2_q[k]);
        b2d_q[k] <= b2_q[k];
        l2_q[k]  <= b2d_q[k] + p2_q[k];
      end
      // level 3 along z
      d3_q  <= l2_q[1] - l2_q[0];
      b3_q  <= l2_q[0];
      p3_q  <= mulq(fdp_q[2][14], d3_q);
      b3d_q <= b3_q;
    end
  end

  // final adder, scaling and saturation into the output register
  logic signed [DW-1:0] r_sum;
  logic signed [DW+gn3d_pkg::OUT_W:0] r_sc;
  logic signed [17:0] sat_d, noise_q;
  assign r_sum = b3d_q + p3_q;
  always_comb begin
    if (F >= gn3d_pkg::OUT_FRAC) begin
      r_sc = (DW+gn3d_pkg::OUT_W+1)'(r_sum >>> (F - gn3d_pkg::OUT_FRAC));
    end else begin
      r_sc = (DW+gn3d_pkg::OUT_W+1)'(r_sum) <<< (gn3d_pkg::OUT_FRAC - F);
    end
    if (r_sc > 131071) sat_d = 18'sd131071;
    else if (r_sc < -131072) sat_d = -18'sd131072;
    else sat_d = 18'(r_sc);
  end

  always_ff @(posedge clk_i) begin
    if (adv) noise_q <= sat_d;
  end
  assign noise_value_o = noise_q;

endmodule

>>> rtl/core/gn3d_checker.sv
// port-level checks for the gradient noise pipeline, bound to the top level
module gn3d_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [17:0] noise_value_o
);

  // input stall only ever comes from a held result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(noise_value_o)))
    else $error("stalled result changed");

  // valid flags and input stall are always known out of reset
  a_hs_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_valid_i, in_stall_o, out_valid_o}))
    else $error("handshake signal unknown");

  // a valid result carries a known value
  a_val_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown(noise_value_o))
    else $error("valid result unknown");

  // output free means input free
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

endmodule

bind gradient_noise_3d gn3d_checker u_gn3d_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .noise_value_o(noise_value_o)
);
